// ----- hdl/vn2d_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the 2D value noise generator.
package vn2d_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_INVERSE_ZOOM = 2'd0;
    localparam logic [1:0] REG_PERSISTENCE  = 2'd1;
    localparam logic [1:0] REG_OCTAVE_COUNT = 2'd2;

    localparam logic [23:0] INVERSE_ZOOM_RST = 24'd223696;
    localparam logic [15:0] PERSISTENCE_RST  = 16'd32768;
    localparam logic [2:0]  OCTAVE_COUNT_RST = 3'd1;

    // Hash constants, all arithmetic is mod 2^31 since bit 31 is masked off
    localparam logic [30:0] HASH_ROW_MUL = 31'd57;
    localparam logic [30:0] HASH_MUL     = 31'd60493;
    localparam logic [30:0] HASH_ADD_A   = 31'd19990303;
    localparam logic [30:0] HASH_ADD_B   = 31'd1376312589;

    localparam logic [16:0] AMP_ONE   = 17'd65536;
    localparam int          OUT_LIMIT = 262144;

    // Pipeline stage numbers handled inside an octave lane, and the total stage count
    localparam int LANE_FIRST = 2;
    localparam int LANE_LAST  = 10;
    localparam int STAGES     = 13;

    localparam longint PI_Q30 = 64'sd3373259426;

    typedef logic [16:0] blend_lut_t [0:255];

    // Truncating quotient of a nonnegative value by a positive constant, shift and subtract
    function automatic longint udiv_small(input longint num, input longint den);
        longint rem;
        longint quo;
        rem = 0;
        quo = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // Cosine blend weight f = (S^2 + 2^15) >> 16, S = round(65536*sin(pi*k/512))
    function automatic blend_lut_t build_blend_lut();
        blend_lut_t lut;
        longint     x;
        longint     x2;
        longint     term;
        longint     acc;
        longint     q;
        longint     f;
        for (int k = 0; k < 256; k++)
        begin
            x    = (longint'(k) * PI_Q30) >>> 9;
            x2   = (x * x) >>> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 5; n++)
            begin
                term = udiv_small((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            if (acc < 0)
                acc = 0;
            q = (acc + 64'sd8192) >>> 14;
            if (q > 65536)
                q = 65536;
            f = (q * q + 64'sd32768) >>> 16;
            lut[k] = 17'(f);
        end
        return lut;
    endfunction

    localparam blend_lut_t BLEND_LUT = build_blend_lut();

    // Seed of the lattice hash: n = x + 57*y, then n ^= n << 13 (mod 2^31)
    function automatic logic [30:0] hash_seed(input logic [30:0] x, input logic [30:0] y);
        logic [30:0] m;
        m = x + 31'(y * HASH_ROW_MUL);
        return m ^ {m[17:0], 13'd0};
    endfunction

    // a + round((b-a)*f / 2^16), half up; p holds (b-a)*f
    function automatic logic signed [17:0] blend_round(input logic signed [17:0] a,
                                                       input logic signed [36:0] p);
        logic signed [37:0] acc;
        acc = (38'(a) <<< 16) + 38'(p) + 38'sd32768;
        return 18'(acc >>> 16);
    endfunction

endpackage

// ----- hdl/vn2d_pixel_if.sv -----
`timescale 1ns / 1ps
// Input channel: one pixel coordinate word.
interface vn2d_pixel_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
    modport monitor (input valid, input pixel_x, input pixel_y, input ready);
endinterface

// ----- hdl/vn2d_noise_if.sv -----
`timescale 1ns / 1ps
// Output channel: one noise sample word.
interface vn2d_noise_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink (input valid, input noise_value, output ready);
    modport monitor (input valid, input noise_value, input ready);
endinterface

// ----- hdl/vn2d_octave.sv -----
`timescale 1ns / 1ps
// One octave lane: lattice hash, two-axis cosine blend and amplitude weighting.
module vn2d_octave
    import vn2d_pkg::*;
#(
    parameter int OCTAVE = 0
)
(
    input  logic                         clk,
    input  logic [LANE_LAST:LANE_FIRST]  stage_en,
    input  logic [35:0]                  cx,
    input  logic [35:0]                  cy,
    input  logic [16:0]                  amp,
    output logic signed [35:0]           weighted
);

    // corners: 0 = (ix,iy), 1 = (ix+1,iy), 2 = (ix,iy+1), 3 = (ix+1,iy+1)
    logic [42:0] sx;
    logic [42:0] sy;
    logic [30:0] ix0;
    logic [30:0] iy0;
    logic [30:0] seed_next [0:3];

    logic [30:0] n2_reg [0:3];
    logic [30:0] n3_reg [0:3];
    logic [30:0] sq3_reg [0:3];
    logic [30:0] n4_reg [0:3];
    logic [30:0] t4_reg [0:3];
    logic signed [17:0] v5_reg [0:3];
    logic [7:0]  kx_reg [2:5];
    logic [7:0]  ky_reg [2:7];

    logic [30:0] h5 [0:3];
    logic signed [17:0] v5_next [0:3];

    logic [16:0] fx;
    logic [16:0] fy;
    logic signed [36:0] p6a_next;
    logic signed [36:0] p6b_next;
    logic signed [36:0] p6a_reg;
    logic signed [36:0] p6b_reg;
    logic signed [17:0] a6a_reg;
    logic signed [17:0] a6b_reg;
    logic signed [17:0] r7a_reg;
    logic signed [17:0] r7b_reg;
    logic signed [36:0] p8_next;
    logic signed [36:0] p8_reg;
    logic signed [17:0] a8_reg;
    logic signed [17:0] s9_reg;
    logic signed [35:0] w10_reg;

    // Octave scaling by 2^OCTAVE is a shift of the Q.24 coordinate
    always_comb
    begin
        sx  = 43'(cx) << OCTAVE;
        sy  = 43'(cy) << OCTAVE;
        ix0 = 31'(sx[42:24]);
        iy0 = 31'(sy[42:24]);
        seed_next[0] = hash_seed(ix0, iy0);
        seed_next[1] = hash_seed(ix0 + 31'd1, iy0);
        seed_next[2] = hash_seed(ix0, iy0 + 31'd1);
        seed_next[3] = hash_seed(ix0 + 31'd1, iy0 + 31'd1);
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            h5[c]      = 31'(n4_reg[c] * t4_reg[c] + HASH_ADD_B);
            v5_next[c] = 18'sd65536 - $signed({1'b0, h5[c][30:14]});
        end
    end

    always_comb
    begin
        fx       = BLEND_LUT[kx_reg[5]];
        fy       = BLEND_LUT[ky_reg[7]];
        p6a_next = (19'(v5_reg[1]) - 19'(v5_reg[0])) * $signed({1'b0, fx});
        p6b_next = (19'(v5_reg[3]) - 19'(v5_reg[2])) * $signed({1'b0, fx});
        p8_next  = (19'(r7b_reg) - 19'(r7a_reg)) * $signed({1'b0, fy});
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            n2_reg    <= seed_next;
            kx_reg[2] <= sx[23:16];
            ky_reg[2] <= sy[23:16];
        end
        if (stage_en[3])
        begin
            for (int c = 0; c < 4; c++)
            begin
                sq3_reg[c] <= 31'(n2_reg[c] * n2_reg[c]);
                n3_reg[c]  <= n2_reg[c];
            end
            kx_reg[3] <= kx_reg[2];
            ky_reg[3] <= ky_reg[2];
        end
        if (stage_en[4])
        begin
            for (int c = 0; c < 4; c++)
            begin
                t4_reg[c] <= 31'(sq3_reg[c] * HASH_MUL + HASH_ADD_A);
                n4_reg[c] <= n3_reg[c];
            end
            kx_reg[4] <= kx_reg[3];
            ky_reg[4] <= ky_reg[3];
        end
        if (stage_en[5])
        begin
            v5_reg    <= v5_next;
            kx_reg[5] <= kx_reg[4];
            ky_reg[5] <= ky_reg[4];
        end
        if (stage_en[6])
        begin
            p6a_reg   <= p6a_next;
            p6b_reg   <= p6b_next;
            a6a_reg   <= v5_reg[0];
            a6b_reg   <= v5_reg[2];
            ky_reg[6] <= ky_reg[5];
        end
        if (stage_en[7])
        begin
            r7a_reg   <= blend_round(a6a_reg, p6a_reg);
            r7b_reg   <= blend_round(a6b_reg, p6b_reg);
            ky_reg[7] <= ky_reg[6];
        end
        if (stage_en[8])
        begin
            p8_reg <= p8_next;
            a8_reg <= r7a_reg;
        end
        if (stage_en[9])
            s9_reg <= blend_round(a8_reg, p8_reg);
        if (stage_en[10])
            w10_reg <= s9_reg * $signed({1'b0, amp});
    end

    assign weighted = w10_reg;

endmodule

// ----- hdl/value_noise_2d_generator.sv -----
`timescale 1ns / 1ps
// Top level of the 2D value noise generator.
// Takes one pixel word per clock and returns one noise word per clock while the
// output side keeps up; a taken word passes 13 register stages to the output
// register. Every octave has its own lane, so the rate is one word per cycle for
// any octave setting; the latency is set by the hash (three chained 31-bit
// multiplies) and the two blend passes. Each stage holds its own valid bit and
// advances whenever the stage ahead is empty or moving, so bubbles close up and the
// input keeps taking words while a result waits at the output. The per-octave
// amplitudes are a registered chain off the persistence register and settle lane
// by lane after a write.
module value_noise_2d_generator
    import vn2d_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int MAX_HEIGHT  = 4096,
    parameter int MAX_OCTAVES = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [23:0]    cfg_data,
    vn2d_pixel_if.sink     pixel,
    vn2d_noise_if.source   noise
);

    // One lane for each summed octave; a single idle lane when none can be summed
    localparam int LANES = (MAX_OCTAVES > 1) ? MAX_OCTAVES - 1 : 1;
    localparam logic [11:0] X_LIMIT = (MAX_WIDTH > 4096) ? 12'hFFF : 12'(MAX_WIDTH - 1);
    localparam logic [11:0] Y_LIMIT = (MAX_HEIGHT > 4096) ? 12'hFFF : 12'(MAX_HEIGHT - 1);

    logic [23:0] inverse_zoom_reg;
    logic [15:0] persistence_reg;
    logic [2:0]  octave_count_reg;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] stage_en;

    logic [11:0] px_reg;
    logic [11:0] py_reg;
    logic [35:0] cx_reg;
    logic [35:0] cy_reg;

    logic [16:0] amp_reg [0:LANES-1];
    logic [16:0] amp_next [0:LANES-1];

    logic signed [35:0] weighted [0:LANES-1];
    logic signed [17:0] contrib_next [0:LANES-1];
    logic signed [17:0] contrib_reg [0:LANES-1];
    logic signed [20:0] sum_next;
    logic signed [19:0] out_next;
    logic signed [19:0] out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_zoom_reg <= INVERSE_ZOOM_RST;
            persistence_reg  <= PERSISTENCE_RST;
            octave_count_reg <= OCTAVE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INVERSE_ZOOM: inverse_zoom_reg <= cfg_data;
                REG_PERSISTENCE:  persistence_reg  <= cfg_data[15:0];
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[2:0];
                default:          ;
            endcase
        end
    end

    // Amplitude chain: amp[i] = round(amp[i-1] * persistence / 2^16)
    always_comb
    begin
        amp_next[0] = AMP_ONE;
        for (int i = 1; i < LANES; i++)
            amp_next[i] = 17'(({16'd0, amp_reg[i-1]} * {17'd0, persistence_reg}
                               + 33'd32768) >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
                amp_reg[i] <= AMP_ONE;
        end
        else
        begin
            amp_reg <= amp_next;
        end
    end

    // Stall chain: a stage loads when it is empty or the stage ahead moves
    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || noise.ready;
        for (int k = STAGES - 2; k >= 0; k--)
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
    end

    assign pixel.ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
                valid_reg[0] <= pixel.valid;
            for (int k = 1; k < STAGES; k++)
            begin
                if (stage_en[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage 0: clamp to the image, stage 1: scale by the reciprocal zoom
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            px_reg <= (pixel.pixel_x > X_LIMIT) ? X_LIMIT : pixel.pixel_x;
            py_reg <= (pixel.pixel_y > Y_LIMIT) ? Y_LIMIT : pixel.pixel_y;
        end
        if (stage_en[1])
        begin
            cx_reg <= {24'd0, px_reg} * {12'd0, inverse_zoom_reg};
            cy_reg <= {24'd0, py_reg} * {12'd0, inverse_zoom_reg};
        end
    end

    // Octave lanes, stages 2 to 10
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        vn2d_octave #(
            .OCTAVE (g)
        ) u_octave (
            .clk      (clk),
            .stage_en (stage_en[LANE_LAST:LANE_FIRST]),
            .cx       (cx_reg),
            .cy       (cy_reg),
            .amp      (amp_reg[g]),
            .weighted (weighted[g])
        );
    end

    // Stage 11: round each weighted sample; lanes past the octave setting add zero
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if ((i + 1 < MAX_OCTAVES) && (4'(i + 1) < {1'b0, octave_count_reg}))
                contrib_next[i] = 18'((weighted[i] + 36'sd32768) >>> 16);
            else
                contrib_next[i] = '0;
        end
    end

    // Stage 12: sum the octaves and saturate
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++)
            sum_next = sum_next + 21'(contrib_reg[i]);
        if (sum_next > 21'sd262144)
            out_next = 20'(OUT_LIMIT);
        else if (sum_next < -21'sd262144)
            out_next = 20'(-OUT_LIMIT);
        else
            out_next = 20'(sum_next);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[11])
            contrib_reg <= contrib_next;
        if (stage_en[12])
            out_reg <= out_next;
    end

    assign noise.valid       = valid_reg[STAGES-1];
    assign noise.noise_value = out_reg;

`ifndef SYNTHESIS
    // Output never leaves the saturation range
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        noise.valid |-> (noise.noise_value <= 20'sd262144) &&
                        (noise.noise_value >= -20'sd262144))
        else $error("noise word out of range");

    // With no octave summed every word is zero
    a_zero_octaves: assert property (@(posedge clk) disable iff (!rst_n)
        (noise.valid && (octave_count_reg <= 3'd1) && $stable(octave_count_reg))
        |-> (noise.noise_value == 20'sd0))
        else $error("nonzero word with no octave summed");

    // An accepted pixel word occupies the first stage next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> valid_reg[0])
        else $error("accepted word lost at stage 0");

    // Input only stalls when the first stage holds a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> valid_reg[0])
        else $error("input stalled with empty first stage");
`endif

endmodule

// ----- dv/vn2d_noise_checker.sv -----
`timescale 1ns / 1ps
// Checker for the 2D value noise generator: predicts each noise word and compares.
module vn2d_noise_checker
    import vn2d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    vn2d_pixel_if.monitor pixel_mon,
    vn2d_noise_if.monitor noise_mon,
    output int            fail_count,
    output int            pending_count
);
    localparam int MAX_OCT = 4;

    logic [23:0] zoom_q24;
    logic [15:0] persist_q16;
    logic [2:0]  octaves;
    logic [16:0] cos_weight [0:255];
    logic signed [19:0] noise_expected [$];

    // Half-up rounding of a Q32 product down to Q16
    function automatic longint round_half_up_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint lattice_value(input logic [31:0] ix, input logic [31:0] iy);
        logic [31:0] n;
        logic [31:0] h;
        n = ix + iy * 32'd57;
        n = (n << 13) ^ n;
        h = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fffffff;
        return 64'sd65536 - longint'(h >> 14);
    endfunction

    function automatic longint cos_blend(input longint a, input longint b,
                                         input logic [23:0] frac);
        longint f;
        f = longint'(cos_weight[frac[23:16]]);
        return round_half_up_q16(a * (64'sd65536 - f) + b * f);
    endfunction

    function automatic logic signed [19:0] noise_at(input logic [11:0] px,
                                                    input logic [11:0] py);
        longint      sum;
        longint      amp;
        longint      r0;
        longint      r1;
        logic [63:0] cx;
        logic [63:0] cy;
        logic [31:0] ix;
        logic [31:0] iy;
        int          cnt;
        sum = 0;
        amp = 65536;
        cnt = (octaves > MAX_OCT) ? MAX_OCT : int'(octaves);
        for (int i = 0; i + 1 < cnt; i++)
        begin
            cx = (64'(px) * 64'(zoom_q24)) << i;
            cy = (64'(py) * 64'(zoom_q24)) << i;
            ix = cx[55:24];
            iy = cy[55:24];
            r0 = cos_blend(lattice_value(ix, iy), lattice_value(ix + 1, iy), cx[23:0]);
            r1 = cos_blend(lattice_value(ix, iy + 1), lattice_value(ix + 1, iy + 1),
                           cx[23:0]);
            sum += round_half_up_q16(cos_blend(r0, r1, cy[23:0]) * amp);
            amp = (amp * longint'(persist_q16) + 32768) >>> 16;
        end
        if (sum > OUT_LIMIT)
            sum = OUT_LIMIT;
        if (sum < -OUT_LIMIT)
            sum = -OUT_LIMIT;
        return 20'(sum);
    endfunction

    initial
    begin
        longint x;
        longint x2;
        longint term;
        longint acc;
        longint q;
        for (int k = 0; k < 256; k++)
        begin
            x    = (longint'(k) * 64'sd3373259426) >>> 9;
            x2   = (x * x) >>> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 5; n++)
            begin
                term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
                acc = (n % 2 == 1) ? acc - term : acc + term;
            end
            if (acc < 0)
                acc = 0;
            q = (acc + 8192) >>> 14;
            if (q > 65536)
                q = 65536;
            cos_weight[k] = 17'((q * q + 32768) >>> 16);
        end
    end

    assign pending_count = noise_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [19:0] want;
        if (!rst_n)
        begin
            zoom_q24    <= INVERSE_ZOOM_RST;
            persist_q16 <= PERSISTENCE_RST;
            octaves     <= OCTAVE_COUNT_RST;
            fail_count  <= 0;
            noise_expected.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INVERSE_ZOOM: zoom_q24    <= cfg_data;
                    REG_PERSISTENCE:  persist_q16 <= cfg_data[15:0];
                    REG_OCTAVE_COUNT: octaves     <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (pixel_mon.valid && pixel_mon.ready)
                noise_expected.insert(noise_expected.size(),
                                      noise_at(pixel_mon.pixel_x, pixel_mon.pixel_y));
            if (noise_mon.valid && noise_mon.ready)
            begin
                if (noise_expected.size() == 0)
                begin
                    $error("noise_value: unexpected word %0d", noise_mon.noise_value);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = noise_expected.pop_front();
                    if (want !== noise_mon.noise_value)
                    begin
                        $error("noise_value: expected %0d, got %0d", want,
                               noise_mon.noise_value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/value_noise_2d_generator_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the 2D value noise generator: stimulus, config phases, verdict.
module value_noise_2d_generator_tb;
    import vn2d_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    vn2d_pixel_if pixel ();
    vn2d_noise_if noise ();

    value_noise_2d_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel.sink),
        .noise     (noise.source)
    );

    vn2d_noise_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_mon     (pixel.monitor),
        .noise_mon     (noise.monitor),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stall: a fresh coin each falling edge
    always @(negedge clk)
        noise.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Send one pixel word; random idle cycles ahead of it, held until taken
    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel.valid <= 1'b0;
            @(negedge clk);
        end
        pixel.valid   <= 1'b1;
        pixel.pixel_x <= px;
        pixel.pixel_y <= py;
        @(posedge clk);
        while (!pixel.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drain, wait out the pipeline, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        pixel.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        // let the amplitude chain settle after a persistence write
        repeat (8) @(negedge clk);
    endtask

    task automatic set_all(input logic [23:0] zoom, input logic [15:0] pers,
                           input logic [2:0] oct);
        write_reg(REG_INVERSE_ZOOM, zoom);
        write_reg(REG_PERSISTENCE, 24'(pers));
        write_reg(REG_OCTAVE_COUNT, 24'(oct));
    endtask

    // Mostly small coordinates so noise varies, some full range
    task automatic random_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                send_pixel(12'($urandom), 12'($urandom));
            else
                send_pixel(12'($urandom_range(300)), 12'($urandom_range(300)));
        end
    endtask

    initial
    begin
        #20ms;
        $display("value_noise_2d_generator_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_INVERSE_ZOOM;
        cfg_data      = '0;
        pixel.valid   = 1'b0;
        pixel.pixel_x = '0;
        pixel.pixel_y = '0;
        noise.ready   = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 63;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: octave count one sums nothing, output must be zero
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hfff, 12'hfff);

        // Directed: extremes of zoom, persistence and octave count
        set_all(24'hffffff, 16'hffff, 3'd4);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hfff, 12'd0);
        send_pixel(12'd0, 12'hfff);
        send_pixel(12'hfff, 12'hfff);
        send_pixel(12'haaa, 12'h555);
        send_pixel(12'h555, 12'haaa);
        // octave counts above the maximum are clamped; zero sums nothing
        write_reg(REG_OCTAVE_COUNT, 24'd7);
        send_pixel(12'h123, 12'h456);
        send_pixel(12'hfff, 12'h001);
        write_reg(REG_OCTAVE_COUNT, 24'd0);
        send_pixel(12'h321, 12'h654);
        // zero zoom collapses every coordinate to the origin lattice point
        set_all(24'd0, 16'd0, 3'd4);
        send_pixel(12'hfff, 12'hfff);
        send_pixel(12'd17, 12'd99);
        set_all(24'd1, 16'h8000, 3'd2);
        send_pixel(12'hfff, 12'hfff);
        send_pixel(12'd1, 12'd2);

        // Random phases: swap idle ratios, then run flat out
        set_all(24'd223696, 16'h8000, 3'd4);
        random_pixels(250);
        send_idle_pct = 63;
        recv_idle_pct = 28;
        set_all(24'($urandom_range(24'hffffff, 1)), 16'($urandom), 3'd3);
        random_pixels(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_all(24'd1 << 22, 16'hffff, 3'd4);
        random_pixels(225);
        set_all(24'($urandom_range(24'hffffff, 1)), 16'($urandom), 3'd2);
        random_pixels(225);

        pixel.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("value_noise_2d_generator_tb: PASS");
        else
            $display("value_noise_2d_generator_tb: FAIL");
        $finish;
    end
endmodule
